// ===== design/slb_pkg.sv =====
// ----------------------------------------------------------------------------
// slb_pkg
// Types, widths and codes shared by the scale lookup table builder.
// ----------------------------------------------------------------------------
`default_nettype none

package slb_pkg;

	localparam int MAX_SIZE   = 4096;
	localparam int FRAC_BITS  = 16;
	localparam int SIZE_W     = 13;
	localparam int DIVIDEND_W = SIZE_W + FRAC_BITS;
	localparam int STEP_W     = DIVIDEND_W;
	localparam int ACC_W      = DIVIDEND_W + 1;
	localparam int INT_W      = ACC_W - FRAC_BITS;
	localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

	typedef enum logic {
		CMD_BEGIN   = 1'b0,
		CMD_ADVANCE = 1'b1
	} cmd_t;

	typedef enum logic {
		TBL_FIRST = 1'b0,
		TBL_LAST  = 1'b1
	} tbl_sel_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		SLOT_BEGIN,
		SLOT_RUN_FIRST,
		SLOT_RUN_LAST,
		SLOT_CLOSE_LAST,
		SLOT_CLOSE_FIRST,
		SLOT_CLOSE_DONE
	} slot_t;

	typedef struct packed {
		logic              cmd;
		logic [SIZE_W-1:0] virtual_size;
		logic [SIZE_W-1:0] real_size;
	} in_item_t;

	typedef struct packed {
		logic              table_select;
		logic [SIZE_W-1:0] entry_index;
		logic [SIZE_W-1:0] entry_value;
		logic              axis_done;
		logic              last_of_run;
	} out_item_t;

	// zero raised to one, above MAX_SIZE lowered to MAX_SIZE
	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
		logic [SIZE_W-1:0] r;
		r = s;
		if (s == '0)
			r = SIZE_W'(1);
		else if (s > SIZE_W'(MAX_SIZE))
			r = SIZE_W'(MAX_SIZE);
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== design/scale_lookup_table_builder.sv =====
// Begin: accept, then divide (one quotient bit per cycle
//   through a shared subtract/compare unit), then its single result.
// Advance: 0, 2, 3 or 5 results, one per cycle unless stalled, via the output register.
// Throughput: one item at a time; in_ready only while the sequencer is idle.
// Reset: arst_n clears the sequencer, output valid and axis state; no axis is active.
// ----------------------------------------------------------------------------
// scale_lookup_table_builder
// Builds one axis of a nearest-neighbor virtual-to-real scale table as a
// stream of first/last table writes, using a serial 13.16 step divider.
// ----------------------------------------------------------------------------
`default_nettype none

module scale_lookup_table_builder (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire slb_pkg::in_item_t in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output slb_pkg::out_item_t     out_data
);
	import slb_pkg::*;

	state_t                state_q, state_d;
	slot_t                 slot_q, slot_d;
	logic                  out_valid_q;
	out_item_t             out_q, out_d;
	logic                  load_out;
	logic                  in_acc;
	logic                  slot_final;

	logic [STEP_W-1:0]     step_q;
	logic [ACC_W-1:0]      acc_q;
	logic [ACC_W-1:0]      prev_acc_q;
	logic [SIZE_W-1:0]     pix_cnt_q;
	logic [SIZE_W-1:0]     held_virtual_q;
	logic [SIZE_W-1:0]     held_real_q;
	logic                  active_q;

	logic                  close_q;
	logic [INT_W-1:0]      run_first_idx_q, run_last_idx_q;
	logic [SIZE_W-1:0]     run_val_q;

	logic [DIVIDEND_W-1:0] div_q;
	logic [SIZE_W-1:0]     rem_q;
	logic [DIV_CNT_W-1:0]  div_cnt_q;
	logic [SIZE_W:0]       trial;
	logic [SIZE_W:0]       diff;
	logic                  ge;
	logic                  div_last;

	logic [INT_W-1:0]      acc_int, prev_int;
	logic                  run_now, close_now;
	logic [SIZE_W:0]       pix_next;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// shared restoring divider step
	assign trial    = {rem_q, div_q[DIVIDEND_W-1]};
	assign diff     = trial - {1'b0, held_real_q};
	assign ge       = (trial >= {1'b0, held_real_q});
	assign div_last = (div_cnt_q == DIV_CNT_W'(DIVIDEND_W - 1));

	assign acc_int   = acc_q[ACC_W-1:FRAC_BITS];
	assign prev_int  = prev_acc_q[ACC_W-1:FRAC_BITS];
	assign run_now   = (acc_int > prev_int);
	assign pix_next  = {1'b0, pix_cnt_q} + (SIZE_W+1)'(1);
	assign close_now = (pix_next >= {1'b0, held_real_q});

	always_comb begin
		out_d      = '0;
		slot_final = 1'b0;
		slot_d     = slot_q;
		unique case (slot_q)
			SLOT_BEGIN: begin
				out_d.table_select = TBL_FIRST;
				out_d.last_of_run  = 1'b1;
				slot_final         = 1'b1;
			end
			SLOT_RUN_FIRST: begin
				out_d.table_select = TBL_FIRST;
				out_d.entry_index  = run_first_idx_q[SIZE_W-1:0];
				out_d.entry_value  = run_val_q;
				slot_d             = SLOT_RUN_LAST;
			end
			SLOT_RUN_LAST: begin
				out_d.table_select = TBL_LAST;
				out_d.entry_index  = run_last_idx_q[SIZE_W-1:0];
				out_d.entry_value  = run_val_q - SIZE_W'(1);
				out_d.last_of_run  = !close_q;
				slot_final         = !close_q;
				slot_d             = SLOT_CLOSE_LAST;
			end
			SLOT_CLOSE_LAST: begin
				out_d.table_select = TBL_LAST;
				out_d.entry_index  = held_virtual_q - SIZE_W'(1);
				out_d.entry_value  = held_real_q - SIZE_W'(1);
				slot_d             = SLOT_CLOSE_FIRST;
			end
			SLOT_CLOSE_FIRST: begin
				out_d.table_select = TBL_FIRST;
				out_d.entry_index  = held_virtual_q;
				out_d.entry_value  = held_real_q;
				slot_d             = SLOT_CLOSE_DONE;
			end
			SLOT_CLOSE_DONE: begin
				out_d.table_select = TBL_LAST;
				out_d.entry_index  = held_virtual_q;
				out_d.entry_value  = held_real_q;
				out_d.axis_done    = 1'b1;
				out_d.last_of_run  = 1'b1;
				slot_final         = 1'b1;
			end
			default: begin
				slot_final = 1'b1;
			end
		endcase
	end

	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (in_data.cmd == CMD_BEGIN)
						state_d = ST_DIV;
					else if (active_q && (run_now || close_now))
						state_d = ST_EMIT;
				end
			end
			ST_DIV: begin
				if (div_last)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					if (slot_final)
						state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out)
			out_q <= out_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q          <= SLOT_BEGIN;
			close_q         <= 1'b0;
			run_first_idx_q <= '0;
			run_last_idx_q  <= '0;
			run_val_q       <= '0;
			step_q          <= '0;
			acc_q           <= '0;
			prev_acc_q      <= '0;
			pix_cnt_q       <= '0;
			held_virtual_q  <= '0;
			held_real_q     <= '0;
			active_q        <= 1'b0;
			div_q           <= '0;
			rem_q           <= '0;
			div_cnt_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && in_data.cmd == CMD_BEGIN) begin
						held_virtual_q <= clamp_size(in_data.virtual_size);
						held_real_q    <= clamp_size(in_data.real_size);
						div_q          <= {clamp_size(in_data.virtual_size), FRAC_BITS'(0)};
						rem_q          <= '0;
						div_cnt_q      <= '0;
						active_q       <= 1'b0;
					end else if (in_acc && active_q) begin
						close_q         <= close_now;
						run_first_idx_q <= acc_int;
						run_last_idx_q  <= prev_int;
						run_val_q       <= pix_cnt_q;
						if (run_now)
							prev_acc_q <= acc_q;
						acc_q     <= acc_q + ACC_W'(step_q);
						pix_cnt_q <= pix_next[SIZE_W-1:0];
						if (close_now)
							active_q <= 1'b0;
						slot_q <= run_now ? SLOT_RUN_FIRST : SLOT_CLOSE_LAST;
					end
				end
				ST_DIV: begin
					div_q     <= {div_q[DIVIDEND_W-2:0], ge};
					rem_q     <= ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
					div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
					if (div_last) begin
						step_q     <= {div_q[DIVIDEND_W-2:0], ge} + STEP_W'(1);
						acc_q      <= '0;
						prev_acc_q <= '0;
						pix_cnt_q  <= '0;
						active_q   <= 1'b1;
						slot_q     <= SLOT_BEGIN;
					end
				end
				ST_EMIT: begin
					if (load_out && !slot_final)
						slot_q <= slot_d;
				end
				default: begin
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_begin_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_data.cmd == CMD_BEGIN)
		|=> (state_q == ST_DIV && div_cnt_q == '0))
		else $error("begin did not start the divider");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.axis_done)
		|-> (out_data.last_of_run && out_data.table_select == TBL_LAST))
		else $error("axis close not on last transaction");

	a_pix_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (pix_cnt_q < held_real_q))
		else $error("pixel counter passed real size");

	a_prev_le_acc: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (prev_acc_q <= acc_q && step_q != '0))
		else $error("accumulator order or step broken");
`endif

endmodule

`default_nettype wire
